>>> hdl/ppmfg_pkg.sv
// ----------------------------------------------------------------------------
// ppmfg_pkg
// Shared types, register indexes and reset constants of the PPM frame
// generator.
// ----------------------------------------------------------------------------
package ppmfg_pkg;

    // Default number of width table entries.
    localparam int MAX_CHANNELS_DEF = 8;

    // Configuration port geometry.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_NUM_CHANNELS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_TICKS  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_GAP_TICKS    = 2'd2;

    // Configuration reset values.
    localparam logic [3:0]  NUM_CHANNELS_RESET = 4'd8;
    localparam logic [15:0] FRAME_TICKS_RESET  = 16'd40000;
    localparam logic [15:0] GAP_TICKS_RESET    = 16'd1000;

    // Width table reset value of entry zero; all other entries reset to zero.
    localparam logic [15:0] WIDTH0_RESET = 16'd1500;

    // Saturation value of the slot elapsed counter.
    localparam logic [16:0] ELAPSED_MAX = 17'h1FFFF;

    // Input item action codes.
    localparam logic ACT_TICK  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    typedef struct packed {
        logic        action;
        logic [2:0]  channel;
        logic [15:0] width_us;
    } ppmfg_in_t;

    typedef struct packed {
        logic ppm_out;
        logic trigger_out;
        logic write_ok;
    } ppmfg_out_t;

endpackage

>>> hdl/ppmfg_ram.sv
// ----------------------------------------------------------------------------
// ppmfg_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module ppmfg_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hdl/ppm_frame_generator.sv
// ----------------------------------------------------------------------------
// ppm_frame_generator
// Radio-control PPM pulse train generator with a channel width table.
// ----------------------------------------------------------------------------
// Usage:
// Each transfer on the s_ channel is either one time tick (0.5 us) or a write
// of one channel width in microseconds. Every input transfer produces exactly
// one result transfer on the m_ channel carrying the PPM level, the frame
// trigger level and a write acknowledge flag.
// The result of a transfer accepted at one clock edge is presented on
// m_valid/m_data right after that edge. Throughput is one item per clock cycle;
// the output register holds one result and s_ready stays high as long as
// that register is empty or being drained in the same cycle.
// The width table lives in a RAM with a registered read. When a slot is armed
// the next width is fetched, and the tick that follows uses the read data
// directly, so the table read never stalls the tick stream.
// When the receiver stalls (m_ready low with a result waiting) s_ready drops
// and the pending result is held unchanged until it is taken.
// Reset (aresetn low, synchronous) returns the configuration registers and the
// timing state to their defaults and empties the output register. The width
// table needs no clearing pass: per-entry valid bits make unwritten entries
// read as 1500 us for channel zero and zero for all others.
// Configuration writes take effect at the clock edge of the write.
// ----------------------------------------------------------------------------
module ppm_frame_generator
    import ppmfg_pkg::*;
#(
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // Configuration write port.
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    // Input item channel.
    input  logic                   s_valid,
    output logic                   s_ready,
    input  ppmfg_in_t              s_data,
    // Result channel.
    output logic                   m_valid,
    input  logic                   m_ready,
    output ppmfg_out_t             m_data
);

    localparam int AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam logic [4:0] MAX_CH5 = 5'(MAX_CHANNELS);

    // Configuration registers.
    logic [3:0]  num_channels_reg;
    logic [15:0] frame_ticks_reg;
    logic [15:0] gap_ticks_reg;

    // Timing state.
    logic [15:0] frame_pos_reg,    frame_pos_next;
    logic [16:0] elapsed_reg,      elapsed_next;
    logic [16:0] target_reg,       target_next;
    logic        end_armed_reg,    end_armed_next;
    logic        rise_armed_reg,   rise_armed_next;
    logic [3:0]  slot_index_reg,   slot_index_next;
    logic        ppm_level_reg,    ppm_level_next;
    logic        trig_level_reg,   trig_level_next;

    // Table read in flight: the returned width becomes the slot end target.
    logic        arm_pend_reg,     arm_pend_next;
    logic        arm_use_ram_reg,  arm_use_ram_next;
    logic        arm_dflt_reg,     arm_dflt_next;

    // Entries that have been written since reset.
    logic [MAX_CHANNELS-1:0] entry_valid_reg;

    // Output register.
    logic        m_valid_reg;
    ppmfg_out_t  m_data_reg;

    logic        in_accept;
    logic        is_tick;
    logic        arm_req;
    logic [3:0]  arm_idx;
    logic [AW-1:0] rd_addr;
    logic        rd_in_table;
    logic [15:0] ram_rdata;
    logic [15:0] width_rd;
    logic [16:0] target_rd;
    logic [16:0] target_eff;
    logic        armed_eff;
    logic [16:0] pos_inc;
    logic [3:0]  chan4;
    logic        write_ok;
    logic        wr_en;
    logic [AW-1:0] wr_addr;

    assign s_ready   = !m_valid_reg || m_ready;
    assign in_accept = s_valid && s_ready;
    assign is_tick   = (s_data.action == ACT_TICK);

    // Width write qualification: the channel must be configured and in the
    // table.
    assign chan4    = {1'b0, s_data.channel};
    assign write_ok = (chan4 < num_channels_reg) && ({1'b0, chan4} < MAX_CH5);
    assign wr_en    = in_accept && !is_tick && write_ok;
    assign wr_addr  = chan4[AW-1:0];

    // Width returned by the table read issued on the previous cycle. Entries
    // never written read as their reset value, and slot indexes past the
    // table read as zero.
    always_comb begin
        if (arm_use_ram_reg) begin
            width_rd = ram_rdata;
        end else if (arm_dflt_reg) begin
            width_rd = WIDTH0_RESET;
        end else begin
            width_rd = '0;
        end
    end

    assign target_rd  = {width_rd, 1'b0};
    assign target_eff = arm_pend_reg ? target_rd : target_reg;
    assign armed_eff  = arm_pend_reg ? (target_rd != '0) : end_armed_reg;

    assign pos_inc = {1'b0, frame_pos_reg} + 17'd1;

    // Tick processing: frame restart, slot end, then rising edge.
    always_comb begin
        frame_pos_next  = frame_pos_reg;
        elapsed_next    = elapsed_reg;
        target_next     = target_eff;
        end_armed_next  = armed_eff;
        rise_armed_next = rise_armed_reg;
        slot_index_next = slot_index_reg;
        ppm_level_next  = ppm_level_reg;
        trig_level_next = trig_level_reg;
        arm_req         = 1'b0;
        arm_idx         = slot_index_reg;

        if (in_accept && is_tick) begin
            if (pos_inc >= {1'b0, frame_ticks_reg}) begin
                frame_pos_next  = '0;
                slot_index_next = '0;
                ppm_level_next  = 1'b0;
                trig_level_next = 1'b1;
                elapsed_next    = '0;
                rise_armed_next = 1'b1;
                arm_req         = 1'b1;
                arm_idx         = '0;
            end else begin
                frame_pos_next = pos_inc[15:0];
                if (elapsed_reg != ELAPSED_MAX) begin
                    elapsed_next = elapsed_reg + 17'd1;
                end

                if (armed_eff && (elapsed_next == target_eff)) begin
                    ppm_level_next  = 1'b0;
                    slot_index_next = slot_index_reg + 4'd1;
                    if (slot_index_next == 4'd1) begin
                        trig_level_next = 1'b0;
                    end
                    elapsed_next    = '0;
                    rise_armed_next = 1'b1;
                    if (slot_index_next != num_channels_reg) begin
                        arm_req = 1'b1;
                        arm_idx = slot_index_next;
                    end else begin
                        end_armed_next = 1'b0;
                    end
                end

                if (rise_armed_next && (elapsed_next == {1'b0, gap_ticks_reg})) begin
                    ppm_level_next  = 1'b1;
                    rise_armed_next = 1'b0;
                end
            end
        end
    end

    // Table read for the slot being armed.
    assign rd_addr     = arm_idx[AW-1:0];
    assign rd_in_table = ({1'b0, arm_idx} < MAX_CH5);

    always_comb begin
        arm_pend_next    = arm_req;
        arm_use_ram_next = rd_in_table && entry_valid_reg[rd_addr];
        arm_dflt_next    = rd_in_table && (rd_addr == '0);
    end

    ppmfg_ram #(
        .WIDTH (16),
        .DEPTH (MAX_CHANNELS)
    ) u_width_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (s_data.width_us),
        .rd_en   (arm_req),
        .rd_addr (rd_addr),
        .rd_data (ram_rdata)
    );

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_channels_reg <= NUM_CHANNELS_RESET;
            frame_ticks_reg  <= FRAME_TICKS_RESET;
            gap_ticks_reg    <= GAP_TICKS_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_NUM_CHANNELS: num_channels_reg <= cfg_wdata[3:0];
                CFG_FRAME_TICKS:  frame_ticks_reg  <= cfg_wdata[15:0];
                CFG_GAP_TICKS:    gap_ticks_reg    <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // Timing state and table bookkeeping.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_pos_reg   <= '0;
            elapsed_reg     <= '0;
            target_reg      <= '0;
            end_armed_reg   <= 1'b0;
            rise_armed_reg  <= 1'b0;
            slot_index_reg  <= '0;
            ppm_level_reg   <= 1'b1;
            trig_level_reg  <= 1'b0;
            arm_pend_reg    <= 1'b0;
            arm_use_ram_reg <= 1'b0;
            arm_dflt_reg    <= 1'b0;
            entry_valid_reg <= '0;
        end else begin
            frame_pos_reg   <= frame_pos_next;
            elapsed_reg     <= elapsed_next;
            target_reg      <= target_next;
            end_armed_reg   <= end_armed_next;
            rise_armed_reg  <= rise_armed_next;
            slot_index_reg  <= slot_index_next;
            ppm_level_reg   <= ppm_level_next;
            trig_level_reg  <= trig_level_next;
            arm_pend_reg    <= arm_pend_next;
            if (arm_req) begin
                arm_use_ram_reg <= arm_use_ram_next;
                arm_dflt_reg    <= arm_dflt_next;
            end
            if (wr_en) begin
                entry_valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    // Output register: loads one result per accepted transfer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (in_accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            m_data_reg.ppm_out     <= ppm_level_next;
            m_data_reg.trigger_out <= trig_level_next;
            m_data_reg.write_ok    <= !is_tick && write_ok;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

>>> hdl/ppmfg_checker.sv
// ----------------------------------------------------------------------------
// ppmfg_checker
// Port-level assertions for the PPM frame generator, bound to the top level.
// ----------------------------------------------------------------------------
module ppmfg_checker
    import ppmfg_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input ppmfg_in_t  s_data,
    input logic       m_valid,
    input logic       m_ready,
    input ppmfg_out_t m_data
);

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result pending after reset");

    // A stalled result holds its value.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    // Every accepted transfer shows a result on the next cycle.
    a_one_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid)
        else $error("accepted transfer produced no result");

    // A tick never acknowledges a write.
    a_tick_no_ack: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_data.action == ACT_TICK) |=> !m_data.write_ok)
        else $error("tick reported write_ok");

    // With no result waiting the block takes input.
    a_ready_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input blocked with empty output register");

endmodule

bind ppm_frame_generator ppmfg_checker u_ppmfg_checker (.*);

>>> verif/ppmfg_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppmfg_scoreboard
// Passive scoreboard for the PPM frame generator: it mirrors the width table,
// the frame and slot timers and the configuration registers, predicts the
// levels and the write flag for every accepted input transfer and compares each
// result transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module ppmfg_scoreboard
    import ppmfg_pkg::*;
#(
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   s_valid,
    input  logic                   s_ready,
    input  ppmfg_in_t              s_data,
    input  logic                   m_valid,
    input  logic                   m_ready,
    input  ppmfg_out_t             m_data,
    output int                     errors,
    output int                     pending,
    output int                     frames_started,
    output int                     writes_refused
);

    // Configuration copy.
    logic [3:0]  chan_count;
    logic [15:0] frame_len;
    logic [15:0] gap_len;

    // Timing state copy.
    logic [15:0] width_mem [MAX_CHANNELS];
    logic [15:0] frame_pos;
    logic [16:0] slot_age;
    logic [16:0] slot_end_at;
    logic        end_live;
    logic        rise_live;
    logic [3:0]  slot_num;
    logic        ppm_lvl;
    logic        trig_lvl;

    ppmfg_out_t  levels_due [$];

    initial begin
        errors         = 0;
        pending        = 0;
        frames_started = 0;
        writes_refused = 0;
    end

    task automatic clear_state();
        chan_count = NUM_CHANNELS_RESET;
        frame_len  = FRAME_TICKS_RESET;
        gap_len    = GAP_TICKS_RESET;
        for (int i = 0; i < MAX_CHANNELS; i++) begin
            width_mem[i] = '0;
        end
        width_mem[0] = WIDTH0_RESET;
        frame_pos    = '0;
        slot_age     = '0;
        slot_end_at  = '0;
        end_live     = 1'b0;
        rise_live    = 1'b0;
        slot_num     = '0;
        ppm_lvl      = 1'b1;
        trig_lvl     = 1'b0;
        levels_due.delete();
    endtask

    // Fetch the width of the current slot; slots past the table never end.
    function automatic void arm_slot_end();
        logic [15:0] w;
        w = '0;
        if (int'(slot_num) < MAX_CHANNELS) begin
            w = width_mem[slot_num];
        end
        slot_end_at = {w, 1'b0};
        end_live    = (slot_end_at != '0);
    endfunction

    function automatic void advance_tick();
        logic [16:0] nxt;
        nxt = {1'b0, frame_pos} + 17'd1;
        if (nxt >= {1'b0, frame_len}) begin
            frame_pos = '0;
            slot_num  = '0;
            ppm_lvl   = 1'b0;
            trig_lvl  = 1'b1;
            slot_age  = '0;
            rise_live = 1'b1;
            arm_slot_end();
            frames_started++;
        end else begin
            frame_pos = nxt[15:0];
            if (slot_age != ELAPSED_MAX) begin
                slot_age = slot_age + 17'd1;
            end
            if (end_live && slot_age == slot_end_at) begin
                ppm_lvl  = 1'b0;
                slot_num = slot_num + 4'd1;
                if (slot_num == 4'd1) begin
                    trig_lvl = 1'b0;
                end
                slot_age  = '0;
                rise_live = 1'b1;
                if (slot_num != chan_count) begin
                    arm_slot_end();
                end else begin
                    end_live = 1'b0;
                end
            end
            if (rise_live && slot_age == {1'b0, gap_len}) begin
                ppm_lvl   = 1'b1;
                rise_live = 1'b0;
            end
        end
    endfunction

    function automatic ppmfg_out_t predict_levels(input ppmfg_in_t item);
        ppmfg_out_t res;
        res = '0;
        if (item.action == ACT_TICK) begin
            advance_tick();
        end else if (item.channel < chan_count && int'(item.channel) < MAX_CHANNELS) begin
            width_mem[item.channel] = item.width_us;
            res.write_ok = 1'b1;
        end else begin
            writes_refused++;
        end
        res.ppm_out     = ppm_lvl;
        res.trigger_out = trig_lvl;
        return res;
    endfunction

    task automatic check_field(input string name, input logic want, input logic got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        ppmfg_out_t want;
        if (!aresetn) begin
            clear_state();
        end else begin
            // A result leaving at this edge belongs to an earlier input.
            if (m_valid && m_ready) begin
                if (levels_due.size() == 0) begin
                    $error("result transfer with no prediction waiting: %b", m_data);
                    errors++;
                end else begin
                    want = levels_due.pop_front();
                    check_field("ppm_out", want.ppm_out, m_data.ppm_out);
                    check_field("trigger_out", want.trigger_out, m_data.trigger_out);
                    check_field("write_ok", want.write_ok, m_data.write_ok);
                end
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_NUM_CHANNELS: chan_count = cfg_wdata[3:0];
                    CFG_FRAME_TICKS:  frame_len  = cfg_wdata[15:0];
                    CFG_GAP_TICKS:    gap_len    = cfg_wdata[15:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                levels_due.push_back(predict_levels(s_data));
            end
        end
        pending = levels_due.size();
    end

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Top level of the PPM frame generator testbench. It drives ticks and channel
// width writes through the input handshake, rewrites the frame, gap and
// channel count registers between phases, stalls the result side on its own
// pattern and reports the verdict that the scoreboard's error count implies.
// ----------------------------------------------------------------------------
module tb;
    import ppmfg_pkg::*;

    // Run control. The cycle limit covers roughly 600 transfers with the
    // slowest receiver pattern, the long hold and all the drains, many times
    // over.
    localparam int CYCLE_LIMIT = 300000;
    localparam int LONG_HOLD   = 160;
    localparam int ITEM_TARGET = 520;
    localparam int SETTLE      = 10;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;
    logic                   s_valid;
    logic                   s_ready;
    ppmfg_in_t              s_data;
    logic                   m_valid;
    logic                   m_ready;
    ppmfg_out_t             m_data;

    int errors;
    int pending;
    int frames_started;
    int writes_refused;

    // Handshake between the sender and the receiver for the long hold-off.
    logic hold_req;
    logic hold_done;

    int cycles;
    int items_sent;
    int ticks_sent;
    int writes_sent;
    int settings_used;

    // Sender pacing state.
    logic gaps_on;
    int   burst_left;

    ppm_frame_generator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    ppmfg_scoreboard u_scoreboard (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data         (s_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data),
        .errors         (errors),
        .pending        (pending),
        .frames_started (frames_started),
        .writes_refused (writes_refused)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Watchdog. If the run has not ended by the limit, something hung.
    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("simulation failed");
        $finish;
    end

    // Receiver. It changes its mind at falling edges, picking a stall
    // pattern for a random stretch of cycles. Once the sender asks for it,
    // the receiver refuses everything for the long hold-off so that the
    // single output register fills and the input side has to back off.
    initial begin
        int stretch;
        int mode;
        int held;
        m_ready   = 1'b0;
        hold_done = 1'b0;
        stretch   = 0;
        mode      = 0;
        held      = 0;
        forever begin
            @(negedge aclk);
            if (hold_req && !hold_done) begin
                m_ready <= 1'b0;
                held++;
                if (held == LONG_HOLD) begin
                    hold_done = 1'b1;
                end
            end else begin
                if (stretch == 0) begin
                    mode    = $urandom_range(0, 3);
                    stretch = $urandom_range(20, 120);
                end
                stretch--;
                case (mode)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= ($urandom_range(0, 1) == 1);
                    2:       m_ready <= ($urandom_range(0, 9) != 0);
                    default: m_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Item builders. The channel and width fields of a tick carry random
    // bits, which the block must ignore.
    function automatic ppmfg_in_t tick_item();
        ppmfg_in_t item;
        item.action   = ACT_TICK;
        item.channel  = 3'($urandom_range(0, 7));
        item.width_us = 16'($urandom());
        return item;
    endfunction

    function automatic ppmfg_in_t width_item(input int ch, input logic [15:0] w);
        ppmfg_in_t item;
        item.action   = ACT_WRITE;
        item.channel  = 3'(ch);
        item.width_us = w;
        return item;
    endfunction

    // Mostly ticks so that the frame timing actually moves; the writes use
    // short widths most of the time so that slot ends fall inside the frame.
    function automatic ppmfg_in_t mixed_item();
        int pick;
        int sel;
        pick = $urandom_range(0, 99);
        sel  = $urandom_range(0, 2);
        if (pick < 84) begin
            return tick_item();
        end else if (pick < 94) begin
            return width_item($urandom_range(0, 7), 16'($urandom_range(0, 20)));
        end else if (sel == 0) begin
            return width_item($urandom_range(0, 7), 16'hFFFF);
        end else if (sel == 1) begin
            return width_item($urandom_range(0, 7), 16'h0000);
        end
        return width_item($urandom_range(0, 7), 16'($urandom()));
    endfunction

    // One transfer. Called at a falling edge; returns at the falling edge after the
    // edge that accepted the item, or after the idle gap that ends a burst. When gaps
    // are on, the sender works in bursts and drops valid between them.
    task automatic offer(input ppmfg_in_t item);
        int idle;
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        items_sent++;
        if (item.action == ACT_TICK) begin
            ticks_sent++;
        end else begin
            writes_sent++;
        end
        if (gaps_on) begin
            burst_left--;
            if (burst_left <= 0) begin
                burst_left = $urandom_range(1, 24);
                idle       = $urandom_range(0, 6);
                if (idle > 0) begin
                    s_valid <= 1'b0;
                    repeat (idle) @(negedge aclk);
                end
            end
        end
    endtask

    // Pause the sender until every predicted result has been taken, then
    // let the block settle before touching its registers.
    task automatic drain();
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (3) @(negedge aclk);
    endtask

    // Rewrite all three registers while the block is idle, one per cycle.
    task automatic program_regs(input logic [3:0] chans, input logic [15:0] frame,
                                input logic [15:0] gap);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_NUM_CHANNELS;
        cfg_wdata <= CFG_DATA_W'(chans);
        @(negedge aclk);
        cfg_index <= CFG_FRAME_TICKS;
        cfg_wdata <= frame;
        @(negedge aclk);
        cfg_index <= CFG_GAP_TICKS;
        cfg_wdata <= gap;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    // Stimulus and verdict.
    initial begin
        int phase;
        int count;
        logic [3:0]  chans;
        logic [15:0] frame;
        logic [15:0] gap;

        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_index     = CFG_NUM_CHANNELS;
        cfg_wdata     = '0;
        s_valid       = 1'b0;
        s_data        = '0;
        hold_req      = 1'b0;
        items_sent    = 0;
        ticks_sent    = 0;
        writes_sent   = 0;
        settings_used = 0;
        gaps_on       = 1'b0;
        burst_left    = 1;

        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part, first under the reset settings: widths at both
        // extremes and alternating bit patterns into several table entries.
        offer(tick_item());
        offer(width_item(0, 16'hFFFF));
        offer(width_item(7, 16'h0000));
        offer(width_item(5, 16'h5555));
        offer(width_item(2, 16'hAAAA));
        offer(tick_item());

        // A frame length of zero makes every tick a frame start, so the zero gap
        // is never compared: no tick gets past the restart. A single channel
        // means a write to channel one is refused.
        program_regs(4'd1, 16'd0, 16'd0);
        offer(width_item(1, 16'd123));
        offer(width_item(0, 16'd1));
        offer(tick_item());
        offer(tick_item());

        // No channels at all: every write is refused, frame length one.
        program_regs(4'd0, 16'd1, 16'd1);
        offer(width_item(0, 16'd7));
        offer(tick_item());
        offer(tick_item());

        // A short frame whose second slot has zero width and never ends.
        program_regs(4'd2, 16'd6, 16'd1);
        offer(width_item(0, 16'd1));
        offer(width_item(1, 16'd0));
        repeat (10) offer(tick_item());

        // Random part, in phases. Each phase programs new settings (the
        // range extremes, channel counts past the table, frames shorter than
        // the current position and random ones), loads a full set of short
        // widths and then runs a mix that is mostly ticks.
        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            chans = 4'($urandom_range(1, 8));
            frame = 16'($urandom_range(40, 300));
            gap   = 16'($urandom_range(1, 12));
            case (phase % 10)
                0: begin chans = 4'd8;  frame = 16'd120;   gap = 16'd3;     end
                1: begin chans = 4'd1;  frame = 16'd2000;  gap = 16'd1;     end
                2: begin chans = 4'd8;  frame = 16'd65535; gap = 16'd65535; end
                4: begin chans = 4'd0;  frame = 16'd300;   gap = 16'd2;     end
                6: begin chans = 4'd12; frame = 16'd250;   gap = 16'd4;     end
                8: begin chans = 4'd8;  frame = 16'd40;    gap = 16'd1;     end
                default: ;
            endcase
            program_regs(chans, frame, gap);

            // The long hold-off lands once, while the sender keeps offering
            // back to back.
            if (phase == 2) begin
                hold_req = 1'b1;
            end
            gaps_on    = (phase % 3 != 0) && (phase != 2);
            burst_left = $urandom_range(1, 24);

            for (int ch = 0; ch < 8; ch++) begin
                if (ch < int'(chans) || ch == 0) begin
                    offer(width_item(ch, ($urandom_range(0, 7) == 0) ? 16'd0 :
                                         16'($urandom_range(1, 15))));
                end
            end
            count = $urandom_range(40, 70);
            repeat (count) offer(mixed_item());
            phase++;
        end

        drain();
        repeat (SETTLE) @(negedge aclk);

        $display("Run covered %0d transfers (%0d ticks, %0d width writes, %0d refused)",
                 items_sent, ticks_sent, writes_sent, writes_refused);
        $display("across %0d register settings with %0d predicted frame starts.",
                 settings_used, frames_started);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
